FILE: rtl/core/rsie_pkg.sv
// ----------------------------------------------------------------------------
// rsie_pkg
// Shared types and encodings for the RV32I subset executor.
// ----------------------------------------------------------------------------
package rsie_pkg;

   localparam int DMEM_BYTES_DEFAULT = 4096;

   // major opcodes
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;

   // funct3 / funct7 codes
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BYTE = 3'd0;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [6:0] F7_ZERO = 7'h00;
   localparam logic [6:0] F7_SRA  = 7'h20;

   // outcome of one instruction leaving execute
   typedef struct packed {
      logic [31:0] next_pc;
      logic        wb_enable;
      logic [4:0]  wb_reg;
      logic [31:0] wb_value;   // zero for loads, filled in after the memory read
      logic        is_load;
      logic        load_byte;
      logic        mem_fault;
   } exec_result_type;

   // data memory access request
   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      logic        word;
      logic [31:0] addr;
      logic [31:0] wdata;
   } dmem_req_type;

endpackage

FILE: rtl/core/riscv_subset_instruction_executor.sv
// ----------------------------------------------------------------------------
// riscv_subset_instruction_executor
// Executes an RV32I subset (LUI, JAL, BEQ, LB, LW, SB, SW, ADD, XOR, ORI,
// SRAI) against an internal pc, register file and data memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | transaction payload
//  --------+-----------+-----------------------------------------------------
//  req_    | in        | instruction word fetched at the current pc
//  rsp_    | out       | next_pc, wb_enable, wb_reg, wb_value, mem_fault
//
//  Pipeline: register read -> execute (S1) -> load align / writeback (S2)
//  -> output register; the register read takes place at the accepting edge.
//  One instruction per cycle sustained while rsp_ready stays high and no
//  interlock holds S1; an instruction that reads the destination of the load
//  just ahead of it waits in S1 until that load has written back (load-use
//  interlock on the data memory's registered read).
//  After reset the data memory is swept to zero, one 4-byte row per cycle,
//  all DMEM_BYTES/4 rows (1024 by default), during which req_ready is low.
//  A stalled rsp_ fills S2 and S1 in turn before req_ready drops.
//
module riscv_subset_instruction_executor #(
   parameter int DMEM_BYTES = rsie_pkg::DMEM_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_wb_enable,
   output logic [4:0]  rsp_wb_reg,
   output logic [31:0] rsp_wb_value,
   output logic        rsp_mem_fault
);
   import rsie_pkg::*;

   // pipeline control
   logic            req_accept;
   logic            s1_valid_ff;
   logic            s1_valid_in;
   logic [31:0]     s1_instr_ff;
   logic [31:0]     s1_instr_in;
   logic            s1_adv;
   logic            s1_hold;
   logic            load_hazard;
   logic            s2_valid_ff;
   logic            s2_valid_in;
   exec_result_type s2_res_ff;
   exec_result_type s2_res_in;
   logic            s2_move;
   logic            out_free;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   exec_result_type out_ff;
   exec_result_type out_in;
   logic [31:0]     pc_ff;
   logic [31:0]     pc_in;

   // datapath
   logic [4:0]      rs1;
   logic [4:0]      rs2;
   logic [4:0]      raddr_a;
   logic [4:0]      raddr_b;
   logic [31:0]     rf_a;
   logic [31:0]     rf_b;
   logic [31:0]     opa;
   logic [31:0]     opb;
   exec_result_type s1_res;
   dmem_req_type    ex_dreq;
   dmem_req_type    dreq;
   logic            dmem_busy;
   logic [31:0]     dmem_rdata;
   logic [31:0]     load_value;
   exec_result_type s2_final;
   logic            rf_we;

   // ---------------- handshake and stage movement ----------------
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s2_move    = s2_valid_ff && out_free;

   assign rs1 = s1_instr_ff[19:15];
   assign rs2 = s1_instr_ff[24:20];

   // loaded value only exists after S2's memory read; hold S1 until it is in the RF
   assign load_hazard = s2_valid_ff && s2_res_ff.is_load && s2_res_ff.wb_enable &&
                        ((s2_res_ff.wb_reg == rs1) || (s2_res_ff.wb_reg == rs2));

   assign s1_adv     = s1_valid_ff && !load_hazard && (!s2_valid_ff || s2_move);
   assign s1_hold    = s1_valid_ff && !s1_adv;
   assign req_ready  = !dmem_busy && (!s1_valid_ff || s1_adv);
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in = req_accept || s1_hold;
   assign s1_instr_in = req_accept ? req_instruction : s1_instr_ff;

   assign s2_valid_in = s1_adv || (s2_valid_ff && !s2_move);
   assign s2_res_in   = s1_adv ? s1_res : s2_res_ff;

   assign rsp_valid_in = s2_move || (rsp_valid_ff && !rsp_ready);
   assign out_in       = s2_move ? s2_final : out_ff;

   assign pc_in = s1_adv ? s1_res.next_pc : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= 32'h0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_instr_ff <= s1_instr_in;
      s2_res_ff   <= s2_res_in;
      out_ff      <= out_in;
   end

   // ---------------- register file ----------------
   // re-read every cycle while S1 waits, so writes retiring meanwhile are seen
   assign raddr_a = s1_hold ? rs1 : req_instruction[19:15];
   assign raddr_b = s1_hold ? rs2 : req_instruction[24:20];

   rsie_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .we      (rf_we),
      .waddr   (s2_res_ff.wb_reg),
      .wdata   (s2_final.wb_value),
      .rdata_a (rf_a),
      .rdata_b (rf_b)
   );

   // forward a non-load result still sitting in S2 (not yet written back)
   always_comb begin
      opa = rf_a;
      opb = rf_b;
      if (s2_valid_ff && s2_res_ff.wb_enable && !s2_res_ff.is_load) begin
         if (s2_res_ff.wb_reg == rs1) begin
            opa = s2_res_ff.wb_value;
         end
         if (s2_res_ff.wb_reg == rs2) begin
            opb = s2_res_ff.wb_value;
         end
      end
   end

   // ---------------- execute ----------------
   rsie_execute #(
      .DMEM_BYTES (DMEM_BYTES)
   ) u_execute (
      .instr (s1_instr_ff),
      .pc    (pc_ff),
      .opa   (opa),
      .opb   (opb),
      .res   (s1_res),
      .dreq  (ex_dreq)
   );

   // memory side effects only when the instruction actually leaves S1
   always_comb begin
      dreq       = ex_dreq;
      dreq.rd_en = ex_dreq.rd_en && s1_adv;
      dreq.wr_en = ex_dreq.wr_en && s1_adv;
   end

   rsie_dmem #(
      .DMEM_BYTES (DMEM_BYTES)
   ) u_dmem (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .busy  (dmem_busy),
      .rdata (dmem_rdata)
   );

   // ---------------- S2: load alignment and writeback ----------------
   // read data holds while S2 stalls: no new read is issued until S2 moves
   assign load_value = s2_res_ff.load_byte ? {{24{dmem_rdata[7]}}, dmem_rdata[7:0]}
                                           : dmem_rdata;

   always_comb begin
      s2_final = s2_res_ff;
      if (s2_res_ff.is_load && s2_res_ff.wb_enable) begin
         s2_final.wb_value = load_value;
      end
      s2_final.is_load   = 1'b0;
      s2_final.load_byte = 1'b0;
   end

   assign rf_we = s2_move && s2_res_ff.wb_enable;

   // ---------------- outputs ----------------
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pc   = out_ff.next_pc;
   assign rsp_wb_enable = out_ff.wb_enable;
   assign rsp_wb_reg    = out_ff.wb_reg;
   assign rsp_wb_value  = out_ff.wb_value;
   assign rsp_mem_fault = out_ff.mem_fault;

   // ---------------- assertions ----------------
   a_no_issue_while_clearing: assert property (@(posedge clock) disable iff (reset)
      dmem_busy |-> !s1_valid_ff)
      else $error("instruction in execute during memory clear");

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (s2_res_ff.wb_reg != 5'd0))
      else $error("register write to x0");

   a_load_use_interlock: assert property (@(posedge clock) disable iff (reset)
      load_hazard |-> !s1_adv)
      else $error("execute advanced past a pending load result");

   a_fault_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_res.mem_fault) |=> (pc_ff == $past(pc_ff)))
      else $error("pc moved on a memory fault");

endmodule

FILE: rtl/core/rsie_regfile.sv
// ----------------------------------------------------------------------------
// rsie_regfile
// 32 x 32 register file, two registered read ports, one write port.
// ----------------------------------------------------------------------------
module rsie_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  raddr_a,
   input  logic [4:0]  raddr_b,
   input  logic        we,
   input  logic [4:0]  waddr,
   input  logic [31:0] wdata,
   output logic [31:0] rdata_a,
   output logic [31:0] rdata_b
);
   import rsie_pkg::*;

   logic [31:0] mem_ff [32];
   logic [31:0] valid_ff;
   logic [31:0] valid_in;
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;
   logic        rv_a_ff;
   logic        rv_b_ff;
   logic        byp_a;
   logic        byp_b;

   // write-first on a same-cycle hit
   assign byp_a = we && (waddr == raddr_a);
   assign byp_b = we && (waddr == raddr_b);

   always_comb begin
      valid_in = valid_ff;
      if (we) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_a_ff <= byp_a ? wdata : mem_ff[raddr_a];
      rd_b_ff <= byp_b ? wdata : mem_ff[raddr_b];
      rv_a_ff <= byp_a || valid_ff[raddr_a];
      rv_b_ff <= byp_b || valid_ff[raddr_b];
   end

   // never-written entries read as zero
   assign rdata_a = rv_a_ff ? rd_a_ff : 32'h0;
   assign rdata_b = rv_b_ff ? rd_b_ff : 32'h0;

endmodule

FILE: rtl/core/rsie_dmem.sv
// ----------------------------------------------------------------------------
// rsie_dmem
// Byte-addressed data memory in four byte banks, unaligned word access,
// zero-clearing sweep after reset.
// ----------------------------------------------------------------------------
module rsie_dmem #(
   parameter int DMEM_BYTES = rsie_pkg::DMEM_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rsie_pkg::dmem_req_type req,
   output logic                  busy,
   output logic [31:0]           rdata
);
   import rsie_pkg::*;

   localparam int AW   = $clog2(DMEM_BYTES);
   localparam int ROWS = (DMEM_BYTES + 3) / 4;
   localparam int RW   = $clog2(ROWS);

   logic          clearing_ff;
   logic          clearing_in;
   logic [RW-1:0] clr_ff;
   logic [RW-1:0] clr_in;
   logic [1:0]    off_ff;
   logic [1:0]    off_in;
   logic [7:0]    bank_rdata [4];

   always_comb begin
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == RW'(ROWS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
   end

   assign off_in = req.rd_en ? req.addr[1:0] : off_ff;

   always_ff @(posedge clock) begin
      off_ff <= off_in;
   end

   assign busy = clearing_ff;

   // bank j holds byte k = (j - addr) mod 4 of the access
   for (genvar j = 0; j < 4; j++) begin : g_bank
      logic [7:0]    mem_ff [ROWS];
      logic [7:0]    rd_ff;
      logic [1:0]    k;
      logic [AW:0]   sum;
      logic [RW-1:0] row;
      logic          we;
      logic [RW-1:0] waddr;
      logic [7:0]    wbyte;

      always_comb begin
         k     = 2'(j) - req.addr[1:0];
         sum   = {1'b0, req.addr[AW-1:0]} + (AW+1)'(k);
         row   = sum[RW+1:2];
         we    = clearing_ff || (req.wr_en && (req.word || (k == 2'd0)));
         waddr = clearing_ff ? clr_ff : row;
         wbyte = clearing_ff ? 8'h00 : req.wdata[8*k +: 8];
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem_ff[waddr] <= wbyte;
         end
         if (req.rd_en) begin
            rd_ff <= mem_ff[row];
         end
      end

      assign bank_rdata[j] = rd_ff;
   end

   // rotate back to little-endian order
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rdata[8*k +: 8] = bank_rdata[2'(off_ff + 2'(k))];
      end
   end

endmodule

FILE: rtl/core/rsie_execute.sv
// ----------------------------------------------------------------------------
// rsie_execute
// Decode, ALU, branch target and memory address/bounds check.
// ----------------------------------------------------------------------------
module rsie_execute #(
   parameter int DMEM_BYTES = rsie_pkg::DMEM_BYTES_DEFAULT
) (
   input  logic [31:0]              instr,
   input  logic [31:0]              pc,
   input  logic [31:0]              opa,
   input  logic [31:0]              opb,
   output rsie_pkg::exec_result_type res,
   output rsie_pkg::dmem_req_type    dreq
);
   import rsie_pkg::*;

   logic [6:0]  op;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [4:0]  shamt;
   logic [6:0]  f7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] pc4;
   logic [31:0] target;
   logic [31:0] addr;
   logic        width_ok;
   logic        in_bounds;
   logic        wr;
   logic        fault;
   logic [31:0] val;
   logic [31:0] npc;

   assign op    = instr[6:0];
   assign rd    = instr[11:7];
   assign f3    = instr[14:12];
   assign shamt = instr[24:20];
   assign f7    = instr[31:25];

   assign imm_i = {{20{instr[31]}}, instr[31:20]};
   assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

   assign pc4    = pc + 32'd4;
   assign target = pc + ((op == OP_JAL) ? imm_j : imm_b);
   assign addr   = opa + ((op == OP_STORE) ? imm_s : imm_i);

   assign width_ok  = (f3 == F3_BYTE) || (f3 == F3_WORD);
   assign in_bounds = (f3 == F3_WORD) ? (addr < 32'(DMEM_BYTES - 3))
                                      : (addr < 32'(DMEM_BYTES));

   always_comb begin
      wr         = 1'b0;
      fault      = 1'b0;
      val        = 32'h0;
      npc        = pc4;
      dreq.rd_en = 1'b0;
      dreq.wr_en = 1'b0;
      dreq.word  = (f3 == F3_WORD);
      dreq.addr  = addr;
      dreq.wdata = opb;
      case (op)
         OP_LUI: begin
            wr  = 1'b1;
            val = {instr[31:12], 12'h000};
         end
         OP_JAL: begin
            wr  = 1'b1;
            val = pc4;
            npc = target;
         end
         OP_BRANCH: begin
            if ((f3 == F3_BEQ) && (opa == opb)) begin
               npc = target;
            end
         end
         OP_LOAD: begin
            if (width_ok) begin
               if (!in_bounds) begin
                  fault = 1'b1;
               end else begin
                  wr         = 1'b1;
                  dreq.rd_en = 1'b1;
               end
            end
         end
         OP_STORE: begin
            if (width_ok) begin
               if (!in_bounds) begin
                  fault = 1'b1;
               end else begin
                  dreq.wr_en = 1'b1;
               end
            end
         end
         OP_REG: begin
            if (f7 == F7_ZERO) begin
               if (f3 == F3_ADD) begin
                  wr  = 1'b1;
                  val = opa + opb;
               end else if (f3 == F3_XOR) begin
                  wr  = 1'b1;
                  val = opa ^ opb;
               end
            end
         end
         OP_IMM: begin
            if (f3 == F3_OR) begin
               wr  = 1'b1;
               val = opa | imm_i;
            end else if ((f3 == F3_SR) && (f7 == F7_SRA)) begin
               wr  = 1'b1;
               val = $signed(opa) >>> shamt;
            end
         end
         default: begin
         end
      endcase
      if (fault) begin
         npc = pc;
         wr  = 1'b0;
      end
      if (rd == 5'd0) begin
         wr = 1'b0;
      end
   end

   assign res.next_pc   = npc;
   assign res.wb_enable = wr;
   assign res.wb_reg    = wr ? rd : 5'd0;
   assign res.wb_value  = (wr && !dreq.rd_en) ? val : 32'h0;
   assign res.is_load   = dreq.rd_en;
   assign res.load_byte = (f3 == F3_BYTE);
   assign res.mem_fault = fault;

endmodule

FILE: bench/rsie_checker.sv
// ----------------------------------------------------------------------------
// rsie_checker
// Watches both channels of the RV32I subset executor. It predicts each
// result from its own copy of pc, register file and data memory, and checks
// every result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rsie_checker #(
   parameter int DMEM_BYTES = rsie_pkg::DMEM_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_instruction,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_next_pc,
   input  logic        rsp_wb_enable,
   input  logic [4:0]  rsp_wb_reg,
   input  logic [31:0] rsp_wb_value,
   input  logic        rsp_mem_fault,
   output int unsigned fail_count,
   output int unsigned pending
);
   import rsie_pkg::*;

   localparam int unsigned REPORT_LIMIT = 200;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        wb_enable;
      logic [4:0]  wb_reg;
      logic [31:0] wb_value;
      logic        mem_fault;
   } retired_type;

   logic [31:0] pc_model;
   logic [31:0] reg_model [32];
   logic [7:0]  dmem_model [DMEM_BYTES];
   retired_type expected_results [$];
   int unsigned results_seen;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < REPORT_LIMIT) begin
         $display("[%0t] mismatch on %s at result %0d: got 0x%08h, expected 0x%08h",
                  $time, what, results_seen, got, want);
      end
      fail_count++;
   endtask

   // executes one instruction against the model state, returns its outcome
   function automatic retired_type execute_instruction(input logic [31:0] word);
      logic [6:0]  opcode;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] imm_i;
      logic [31:0] imm_s;
      logic [31:0] imm_b;
      logic [31:0] imm_j;
      logic [31:0] addr;
      logic [31:0] span;
      logic [31:0] npc;
      logic [31:0] val;
      logic        wr;
      logic        fault;
      logic        oob;
      retired_type res;
      opcode = word[6:0];
      rd     = word[11:7];
      f3     = word[14:12];
      rs1    = word[19:15];
      rs2    = word[24:20];
      f7     = word[31:25];
      a      = reg_model[rs1];
      b      = reg_model[rs2];
      imm_i  = {{20{word[31]}}, word[31:20]};
      imm_s  = {{20{word[31]}}, word[31:25], word[11:7]};
      imm_b  = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
      imm_j  = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
      npc    = pc_model + 32'd4;
      wr     = 1'b0;
      fault  = 1'b0;
      val    = '0;
      // shared by loads and stores; the sum wraps, so negative offsets from
      // a small base land far outside memory
      addr   = a + ((opcode == OP_STORE) ? imm_s : imm_i);
      span   = (f3 == F3_WORD) ? 32'd3 : 32'd0;
      oob    = (addr >= 32'(DMEM_BYTES)) || (addr + span >= 32'(DMEM_BYTES));

      if (opcode == OP_LUI) begin
         wr  = 1'b1;
         val = {word[31:12], 12'h000};
      end else if (opcode == OP_JAL) begin
         wr  = 1'b1;
         val = pc_model + 32'd4;
         npc = pc_model + imm_j;
      end else if (opcode == OP_BRANCH) begin
         if (f3 == F3_BEQ && a == b) npc = pc_model + imm_b;
      end else if (opcode == OP_LOAD && (f3 == F3_BYTE || f3 == F3_WORD)) begin
         if (oob) begin
            fault = 1'b1;
         end else if (f3 == F3_BYTE) begin
            wr  = 1'b1;
            val = {{24{dmem_model[addr][7]}}, dmem_model[addr]};
         end else begin
            wr  = 1'b1;
            val = {dmem_model[addr + 32'd3], dmem_model[addr + 32'd2],
                   dmem_model[addr + 32'd1], dmem_model[addr]};
         end
      end else if (opcode == OP_STORE && (f3 == F3_BYTE || f3 == F3_WORD)) begin
         if (oob) begin
            fault = 1'b1;
         end else begin
            dmem_model[addr] = b[7:0];
            if (f3 == F3_WORD) begin
               dmem_model[addr + 32'd1] = b[15:8];
               dmem_model[addr + 32'd2] = b[23:16];
               dmem_model[addr + 32'd3] = b[31:24];
            end
         end
      end else if (opcode == OP_REG && f7 == F7_ZERO) begin
         if (f3 == F3_ADD) begin
            wr  = 1'b1;
            val = a + b;
         end else if (f3 == F3_XOR) begin
            wr  = 1'b1;
            val = a ^ b;
         end
      end else if (opcode == OP_IMM) begin
         if (f3 == F3_OR) begin
            wr  = 1'b1;
            val = a | imm_i;
         end else if (f3 == F3_SR && f7 == F7_SRA) begin
            wr  = 1'b1;
            val = $signed(a) >>> rs2;
         end
      end

      // a faulting access retires nothing and holds the pc
      if (fault) begin
         npc = pc_model;
         wr  = 1'b0;
      end
      if (rd == 5'd0) wr = 1'b0;
      if (wr) reg_model[rd] = val;
      pc_model = npc;

      res.next_pc   = npc;
      res.wb_enable = wr;
      res.wb_reg    = wr ? rd : 5'd0;
      res.wb_value  = wr ? val : 32'd0;
      res.mem_fault = fault;
      return res;
   endfunction

   always @(posedge clock) begin
      retired_type want;
      if (reset) begin
         pc_model = '0;
         for (int i = 0; i < 32; i++) reg_model[i] = '0;
         for (int i = 0; i < DMEM_BYTES; i++) dmem_model[i] = '0;
         expected_results.delete();
         results_seen = 0;
      end else begin
         // result side first: a result can never belong to this edge's input
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_next_pc, 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_next_pc !== want.next_pc)
                  report_mismatch("next_pc", rsp_next_pc, want.next_pc);
               if (rsp_wb_enable !== want.wb_enable)
                  report_mismatch("wb_enable", 32'(rsp_wb_enable), 32'(want.wb_enable));
               if (rsp_wb_reg !== want.wb_reg)
                  report_mismatch("wb_reg", 32'(rsp_wb_reg), 32'(want.wb_reg));
               if (rsp_wb_value !== want.wb_value)
                  report_mismatch("wb_value", rsp_wb_value, want.wb_value);
               if (rsp_mem_fault !== want.mem_fault)
                  report_mismatch("mem_fault", 32'(rsp_mem_fault), 32'(want.mem_fault));
            end
            results_seen++;
         end
         if (req_valid && req_ready)
            expected_results.push_back(execute_instruction(req_instruction));
      end
      pending = expected_results.size();
   end

endmodule

FILE: bench/riscv_subset_instruction_executor_tb.sv
// ----------------------------------------------------------------------------
// riscv_subset_instruction_executor_tb
// Drives instruction transactions into the executor and takes its results
// with random gaps on both sides, a long receiver hold-off and a drain pause.
// A directed program covers each operation and the boundary cases, then a
// weighted random stream follows. The checker predicts and compares; this
// module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module riscv_subset_instruction_executor_tb;
   import rsie_pkg::*;

   // funct3 codes the block does not support, used to hit the no-op paths
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_HALF = 3'd1;

   localparam int unsigned RANDOM_ITEMS     = 850;
   localparam int unsigned DRAIN_AT_ITEM    = 600;
   // receiver holds off once, after this many results, for this many cycles;
   // the pipeline is three deep so the input stalls well before the end
   localparam int unsigned HOLD_AFTER       = 400;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   // gaps are switched off for the first 40 transactions of every 200
   localparam int unsigned BURST_PERIOD     = 200;
   localparam int unsigned BURST_LENGTH     = 40;
   // settle time after the final drain, to catch any stray result
   localparam int unsigned SETTLE_CYCLES    = 12;
   // longest legal quiet stretch: the memory sweep after reset, the long
   // receiver hold-off or the longest random gap; taken several times over
   localparam int unsigned WATCHDOG_LIMIT   = 6000;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [31:0] req_instruction = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_wb_enable;
   logic [4:0]  rsp_wb_reg;
   logic [31:0] rsp_wb_value;
   logic        rsp_mem_fault;

   int unsigned mismatch_total;
   int unsigned outstanding;
   int unsigned rsp_count   = 0;
   int unsigned idle_cycles = 0;
   logic        long_hold_done = 1'b0;

   riscv_subset_instruction_executor DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_instruction (req_instruction),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_wb_enable   (rsp_wb_enable),
      .rsp_wb_reg      (rsp_wb_reg),
      .rsp_wb_value    (rsp_wb_value),
      .rsp_mem_fault   (rsp_mem_fault)
   );

   rsie_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_instruction (req_instruction),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_wb_enable   (rsp_wb_enable),
      .rsp_wb_reg      (rsp_wb_reg),
      .rsp_wb_value    (rsp_wb_value),
      .rsp_mem_fault   (rsp_mem_fault),
      .fail_count      (mismatch_total),
      .pending         (outstanding)
   );

   // 8-unit period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: any transaction on either channel restarts the count. Also
   // keeps the result count that paces the receiver.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (rsp_valid && rsp_ready) rsp_count <= rsp_count + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, outstanding);
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Instruction encoders
   // ---------------------------------------------------------------------
   function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3,
                                         input logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OP_REG};
   endfunction

   function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [6:0] opcode);
      return {imm, rs1, f3, rd, opcode};
   endfunction

   function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction

   function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd);
      return {imm, rd, OP_LUI};
   endfunction

   function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
   endfunction

   // ---------------------------------------------------------------------
   // Random stream
   // ---------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // A handful of registers carries most traffic so that back-to-back
   // dependencies (forwarding, load-use) come up often.
   function automatic logic [4:0] pick_reg();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 5'($urandom_range(1, 7));
      if (r < 70) return 5'd0;
      return 5'($urandom());
   endfunction

   // Base and offset for a memory access. x30 is kept at 4096 by the stream,
   // so negative offsets from it reach the top of memory; x0 with positive
   // offsets reaches the bottom. Both have a hot corner of 64 bytes so that
   // loads find earlier stores.
   function automatic void mem_operand(output logic [4:0] base, output logic [11:0] offset);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         base   = 5'd0;
         offset = (r < 25) ? 12'($urandom_range(0, 63)) : 12'($urandom_range(0, 2047));
      end else if (r < 90) begin
         base   = 5'd30;
         offset = (r < 70) ? 12'($urandom_range(4032, 4095))
                           : 12'($urandom_range(2048, 4095));
      end else begin
         base   = pick_reg();
         offset = 12'($urandom());
      end
   endfunction

   function automatic logic [31:0] random_instruction();
      int unsigned kind;
      int unsigned r;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [11:0] imm;
      kind = $urandom_range(0, 99);
      r    = $urandom_range(0, 99);
      rd   = pick_reg();
      rs1  = pick_reg();
      rs2  = pick_reg();
      // load and store widths: mostly byte or word, sometimes anything
      f3   = (r < 85) ? ((r % 2) ? F3_WORD : F3_BYTE) : 3'($urandom());
      if (kind < 8)  return enc_u(20'($urandom()), rd);
      if (kind < 11) return enc_u(20'h00001, 5'd30);          // restore the high base
      if (kind < 16) return enc_j(21'($urandom()), rd);
      if (kind < 24) return enc_b(13'($urandom()), rs2, rs1, (r < 80) ? F3_BEQ : 3'($urandom()));
      if (kind < 42) begin
         mem_operand(rs1, imm);
         return enc_i(imm, rs1, f3, rd, OP_LOAD);
      end
      if (kind < 60) begin
         mem_operand(rs1, imm);
         return enc_s(imm, rs2, rs1, f3);
      end
      if (kind < 74) begin
         f7 = (r < 90) ? F7_ZERO : 7'($urandom());
         f3 = (r < 50) ? F3_ADD : ((r < 90) ? F3_XOR : 3'($urandom()));
         return enc_r(f7, rs2, rs1, f3, rd);
      end
      if (kind < 88) begin
         if (r < 45) return enc_i(12'($urandom()), rs1, F3_OR, rd, OP_IMM);
         if (r < 90) return enc_i({(r < 85) ? F7_SRA : 7'($urandom()), 5'($urandom())},
                                  rs1, F3_SR, rd, OP_IMM);
         return enc_i(12'($urandom()), rs1, 3'($urandom()), rd, OP_IMM);
      end
      // raw words: every bit of every field, mostly unsupported encodings
      return $urandom();
   endfunction

   // ---------------------------------------------------------------------
   // Sender: called at a falling edge, returns at the falling edge after
   // the transaction was taken, with valid still high.
   // ---------------------------------------------------------------------
   task automatic send_instruction(input logic [31:0] word);
      req_valid       <= 1'b1;
      req_instruction <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // payload is scrambled while idle; the block must not look at it
   task automatic pause_sender(input int unsigned cycles);
      if (cycles > 0) begin
         req_valid       <= 1'b0;
         req_instruction <= $urandom();
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: one decision per falling edge. Outside burst windows it
   // stalls at random; once, after HOLD_AFTER results, it holds off long
   // enough for the block to back up into its input.
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            if (!long_hold_done && rsp_count >= HOLD_AFTER) begin
               long_hold_done = 1'b1;
               stall_left     = LONG_HOLD_CYCLES;
            end else if ((rsp_count % BURST_PERIOD) >= BURST_LENGTH) begin
               stall_left = idle_gap();
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and verdict
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] directed_words [$];
      int unsigned n;
      directed_words = '{
         enc_u(20'hFFFFF, 5'd1),                             // LUI, top immediate
         enc_i(12'hFFF, 5'd0, F3_OR, 5'd2, OP_IMM),          // ORI all ones
         enc_i(12'h7FF, 5'd0, F3_OR, 5'd3, OP_IMM),          // ORI largest positive
         enc_r(F7_ZERO, 5'd3, 5'd2, F3_ADD, 5'd4),           // ADD with carry out
         enc_r(F7_ZERO, 5'd3, 5'd1, F3_XOR, 5'd5),
         enc_i({F7_SRA, 5'd31}, 5'd1, F3_SR, 5'd6, OP_IMM),  // SRAI full shift
         enc_u(20'h00001, 5'd30),                            // x30 = memory size
         enc_s(12'hFFC, 5'd2, 5'd30, F3_WORD),               // SW at the last word
         enc_s(12'hFFD, 5'd2, 5'd30, F3_WORD),               // SW straddling the end
         enc_s(12'hFFF, 5'd4, 5'd30, F3_BYTE),               // SB at the last byte
         enc_i(12'hFFC, 5'd30, F3_WORD, 5'd8, OP_LOAD),      // LW at the last word
         enc_i(12'hFFF, 5'd30, F3_BYTE, 5'd9, OP_LOAD),      // LB, negative byte
         enc_r(F7_ZERO, 5'd8, 5'd9, F3_ADD, 5'd10),          // uses the load just ahead
         enc_i(12'h000, 5'd30, F3_BYTE, 5'd11, OP_LOAD),     // LB one past the end
         enc_i(12'hFFF, 5'd0, F3_WORD, 5'd12, OP_LOAD),      // address wraps to all ones
         enc_s(12'h001, 5'd1, 5'd0, F3_WORD),                // unaligned SW
         enc_i(12'h001, 5'd0, F3_WORD, 5'd13, OP_LOAD),      // unaligned LW
         enc_i({F7_SRA, 5'd4}, 5'd13, F3_SR, 5'd14, OP_IMM), // load-use into SRAI
         enc_b(13'h1FF8, 5'd0, 5'd0, F3_BEQ),                // taken, backwards
         enc_b(13'h0010, 5'd2, 5'd1, F3_BEQ),                // not taken
         enc_b(13'h0FFE, 5'd0, 5'd0, F3_BNE),                // other condition: never taken
         enc_j(21'h0FFFFE, 5'd15),                           // JAL furthest forward
         enc_j(21'h100000, 5'd0),                            // JAL furthest back, to x0
         enc_i(12'h000, 5'd0, F3_HALF, 5'd16, OP_LOAD),      // unsupported load width
         32'hFFFF_FFFF                                       // unsupported opcode
      };

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed program; the first one waits out the post-reset sweep
      foreach (directed_words[i]) begin
         send_instruction(directed_words[i]);
         pause_sender(idle_gap());
      end
      drain_results();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // sender pauses until the block has handed back every result
         if (n == DRAIN_AT_ITEM) drain_results();
         send_instruction(random_instruction());
         if ((n % BURST_PERIOD) >= BURST_LENGTH) pause_sender(idle_gap());
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_total == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rsie_pkg.sv
rtl/core/rsie_regfile.sv
rtl/core/rsie_dmem.sv
rtl/core/rsie_execute.sv
rtl/core/riscv_subset_instruction_executor.sv
bench/rsie_checker.sv
bench/riscv_subset_instruction_executor_tb.sv
